/* hdl/spm_pkg.sv */
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants for the segmented paging unit with LRU
// ----------------------------------------------------------------------------
package spm_pkg;

	localparam int ADDR_W          = 18;
	localparam int OFS_W           = 12;
	localparam int SEG_SLOTS       = 4;
	localparam int SEG_W           = 2;
	localparam int PIDX_W          = 4;
	localparam int PAGES_PER_SEG   = 16;
	localparam int SLOT_W          = SEG_W + PIDX_W;
	localparam int PAGES_W         = 5;
	localparam int FRAME_COUNT_DEF = 64;
	localparam int PADDR_W         = 5;
	localparam int DATA_W          = 32;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_NO_SEG    = 2'd1,
		ERR_READ_ONLY = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		REG_SEG_COUNT = 3'd0,
		REG_PAGES_0   = 3'd1,
		REG_PAGES_1   = 3'd2,
		REG_PAGES_2   = 3'd3,
		REG_PAGES_3   = 3'd4,
		REG_WMASK     = 3'd5
	} reg_idx_t;

endpackage

/* hdl/spm_cell.sv */
// ----------------------------------------------------------------------------
// spm_cell
// One recency slot: holds a used frame and its owner page, shifts from the
// more recent neighbor when the list moves
// ----------------------------------------------------------------------------
module spm_cell import spm_pkg::*; #(
	parameter int FRAME_W = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd,
	input  logic [SLOT_W-1:0]  key,
	input  logic               seen_in,
	output logic               seen_out,
	input  logic [FRAME_W-1:0] hit_frame_in,
	output logic [FRAME_W-1:0] hit_frame_out,
	input  logic               left_valid,
	input  logic [FRAME_W-1:0] left_frame,
	input  logic [SLOT_W-1:0]  left_owner,
	output logic               valid,
	output logic [FRAME_W-1:0] frame,
	output logic [SLOT_W-1:0]  owner
);

	logic valid_q;
	logic [FRAME_W-1:0] frame_q;
	logic [SLOT_W-1:0] owner_q;
	logic match;

	assign match         = valid_q && (owner_q == key);
	assign seen_out      = seen_in | match;
	assign hit_frame_out = (match && !seen_in) ? frame_q : hit_frame_in;
	assign valid         = valid_q;
	assign frame         = frame_q;
	assign owner         = owner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd && !seen_in) begin
			valid_q <= left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && !seen_in) begin
			frame_q <= left_frame;
			owner_q <= left_owner;
		end
	end

endmodule

/* hdl/segmented_paging_mmu_lru.sv */
// ----------------------------------------------------------------------------
// segmented_paging_mmu_lru
// Segment decode, page lookup and LRU frame replacement on a row of cells
// ----------------------------------------------------------------------------
// Input channel: mode and virt_addr, transfer on in_valid && !in_stall.
// Output channel: phys_addr, page_fault, evicted, error, transfer on
// out_valid && !out_stall. Exactly one result per input transfer, in order.
// Each access goes through four steps: accept, segment decode, lookup across
// the recency cells, and update of the cells plus loading of the output
// register. No new access is taken until the update step is done, as the
// single shared cell row serves both lookup and recency move. Configuration
// goes through the APB port (pready always high); the user must do so only
// while the block is idle, which the block does not enforce. Reset clears the
// configuration, empties the recency row (no page mapped) and drops
// out_valid. A stalled result holds in the output register; the next access
// is still taken and waits in the update step until the register is free.
// ----------------------------------------------------------------------------
module segmented_paging_mmu_lru import spm_pkg::*; #(
	parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [ADDR_W-1:0]  virt_addr,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [ADDR_W-1:0]  phys_addr,
	output logic               page_fault,
	output logic               evicted,
	output logic [1:0]         error
);

	localparam int FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int LEN_W   = $clog2(FRAME_COUNT + 1);

	typedef enum logic [1:0] {S_IDLE, S_DECODE, S_LOOKUP, S_UPDATE} state_t;

	state_t state_q;
	logic [2:0] seg_count_q;
	logic [PAGES_W-1:0] pages_q [SEG_SLOTS];
	logic [SEG_SLOTS-1:0] wmask_q;

	logic mode_q;
	logic [ADDR_W-1:0] vaddr_q;
	logic found_q, ro_q, hit_q;
	logic [SEG_W-1:0] seg_q;
	logic [PIDX_W-1:0] pidx_q;
	logic [OFS_W-1:0] ofs_q;
	logic [FRAME_W-1:0] hit_frame_q;
	logic [LEN_W-1:0] len_q;

	// configuration port
	logic wr_en;
	logic [2:0] widx;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign widx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= '0;
			wmask_q     <= '0;
			for (int s = 0; s < SEG_SLOTS; s++) pages_q[s] <= '0;
		end else if (wr_en) begin
			unique case (widx)
				REG_SEG_COUNT: seg_count_q <= pwdata[2:0];
				REG_PAGES_0:   pages_q[0] <= pwdata[PAGES_W-1:0];
				REG_PAGES_1:   pages_q[1] <= pwdata[PAGES_W-1:0];
				REG_PAGES_2:   pages_q[2] <= pwdata[PAGES_W-1:0];
				REG_PAGES_3:   pages_q[3] <= pwdata[PAGES_W-1:0];
				REG_WMASK:     wmask_q <= pwdata[SEG_SLOTS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_SEG_COUNT: prdata = DATA_W'(seg_count_q);
			REG_PAGES_0:   prdata = DATA_W'(pages_q[0]);
			REG_PAGES_1:   prdata = DATA_W'(pages_q[1]);
			REG_PAGES_2:   prdata = DATA_W'(pages_q[2]);
			REG_PAGES_3:   prdata = DATA_W'(pages_q[3]);
			REG_WMASK:     prdata = DATA_W'(wmask_q);
			default:       prdata = '0;
		endcase
	end

	// segment decode
	logic [2:0] eff_count;
	logic [ADDR_W:0] base, seg_end;
	logic [PAGES_W-1:0] pg;
	logic d_found;
	logic [SEG_W-1:0] d_seg;
	logic [ADDR_W:0] d_rel;

	always_comb begin
		eff_count = (seg_count_q > 3'(SEG_SLOTS)) ? 3'(SEG_SLOTS) : seg_count_q;
		base    = '0;
		seg_end = '0;
		pg      = '0;
		d_found = 1'b0;
		d_seg   = '0;
		d_rel   = '0;
		for (int s = 0; s < SEG_SLOTS; s++) begin
			pg = (pages_q[s] > PAGES_W'(PAGES_PER_SEG)) ? PAGES_W'(PAGES_PER_SEG) : pages_q[s];
			seg_end = base + ((ADDR_W+1)'(pg) << OFS_W);
			if (!d_found && (3'(s) < eff_count) && ({1'b0, vaddr_q} >= base)
					&& ({1'b0, vaddr_q} < seg_end)) begin
				d_found = 1'b1;
				d_seg   = SEG_W'(s);
				d_rel   = {1'b0, vaddr_q} - base;
			end
			base = seg_end;
		end
	end

	// recency cells, index 0 is most recent
	logic [SLOT_W-1:0] key;
	logic seen [FRAME_COUNT+1];
	logic [FRAME_W-1:0] hf [FRAME_COUNT+1];
	logic c_valid [FRAME_COUNT];
	logic [FRAME_W-1:0] c_frame [FRAME_COUNT];
	logic [SLOT_W-1:0] c_owner [FRAME_COUNT];
	logic upd, out_free, full;
	logic [FRAME_W-1:0] new_frame;

	assign key      = {seg_q, pidx_q};
	assign seen[0]  = 1'b0;
	assign hf[0]    = '0;
	assign out_free = !out_valid || !out_stall;
	assign full     = c_valid[FRAME_COUNT-1];
	assign upd      = (state_q == S_UPDATE) && out_free && found_q;
	// frames fill from zero upward and are only freed to be reused at once
	assign new_frame = hit_q ? hit_frame_q :
		(full ? c_frame[FRAME_COUNT-1] : len_q[FRAME_W-1:0]);

	for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
		spm_cell #(.FRAME_W(FRAME_W)) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.upd           (upd),
			.key           (key),
			.seen_in       (seen[i]),
			.seen_out      (seen[i+1]),
			.hit_frame_in  (hf[i]),
			.hit_frame_out (hf[i+1]),
			.left_valid    ((i == 0) ? 1'b1 : c_valid[(i == 0) ? 0 : i-1]),
			.left_frame    ((i == 0) ? new_frame : c_frame[(i == 0) ? 0 : i-1]),
			.left_owner    ((i == 0) ? key : c_owner[(i == 0) ? 0 : i-1]),
			.valid         (c_valid[i]),
			.frame         (c_frame[i]),
			.owner         (c_owner[i])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_DECODE;
				S_DECODE: state_q <= S_LOOKUP;
				S_LOOKUP: state_q <= S_UPDATE;
				S_UPDATE: if (out_free) begin
					state_q <= S_IDLE;
					if (found_q && !hit_q && !full) len_q <= len_q + 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			mode_q  <= mode;
			vaddr_q <= virt_addr;
		end
		if (state_q == S_DECODE) begin
			found_q <= d_found;
			seg_q   <= d_seg;
			pidx_q  <= d_rel[OFS_W +: PIDX_W];
			ofs_q   <= d_rel[OFS_W-1:0];
			ro_q    <= mode_q && !wmask_q[d_seg];
		end
		if (state_q == S_LOOKUP) begin
			hit_q       <= seen[FRAME_COUNT];
			hit_frame_q <= hf[FRAME_COUNT];
		end
	end

	assign in_stall = (state_q != S_IDLE);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_UPDATE && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPDATE && out_free) begin
			if (found_q) begin
				phys_addr  <= ADDR_W'({new_frame, ofs_q});
				page_fault <= !hit_q;
				evicted    <= !hit_q && full;
				error      <= ro_q ? ERR_READ_ONLY : ERR_NONE;
			end else begin
				phys_addr  <= '0;
				page_fault <= 1'b0;
				evicted    <= 1'b0;
				error      <= ERR_NO_SEG;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) len_q <= LEN_W'(FRAME_COUNT))
		else $error("recency length beyond frame count");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted |-> page_fault)
		else $error("eviction without fault");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error == ERR_NO_SEG |-> phys_addr == '0 && !page_fault)
		else $error("unmapped address produced translation");
	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> len_q == LEN_W'(FRAME_COUNT))
		else $error("full row with short length");

endmodule
